### hw/rtl/assert_macros.svh
// assertion helpers for the top-level rtl file
// each check is disabled while the asynchronous reset is asserted
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// consequent holds at the edge after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/cvg_pkg.sv
// ----------------------------------------------------------------------------
// cvg_pkg
// Types and constants of the corexy velocity command gate: request and
// result payloads, per-motor result, register map and rate limits.
// ----------------------------------------------------------------------------
package cvg_pkg;

	// fixed-point layout
	localparam int VEL_W   = 24;
	localparam int GAIN_W  = 32;
	localparam int PROD_W  = VEL_W + GAIN_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int FRAC_W  = 24;
	localparam int WHOLE_W = SUM_W - FRAC_W;
	localparam int RATE_W  = 24;
	localparam int DB_W    = 16;

	// saturation limits of the step-rate magnitude
	localparam logic [RATE_W-1:0] RATE_MAX_POS = 24'h7FFFFF;
	localparam logic [RATE_W-1:0] RATE_MAX_NEG = 24'h800000;

	localparam logic [DB_W-1:0] DEADBAND_RESET = 16'd30;

	// limit switch bit positions
	localparam int SW_LEFT   = 0;
	localparam int SW_RIGHT  = 1;
	localparam int SW_BOTTOM = 2;
	localparam int SW_TOP    = 3;

	// apb register map, word index
	localparam int ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_LEFT_GAIN_X  = 3'd0,
		REG_LEFT_GAIN_Y  = 3'd1,
		REG_RIGHT_GAIN_X = 3'd2,
		REG_RIGHT_GAIN_Y = 3'd3,
		REG_DEADBAND     = 3'd4
	} cvg_reg_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic [3:0]              limit_switches;
	} cvg_cmd_t;

	typedef struct packed {
		logic              stop;
		logic [RATE_W-1:0] rate;
		logic              move;
		logic              forward;
	} cvg_motor_t;

	typedef struct packed {
		logic              left_halt;
		logic [RATE_W-1:0] left_rate;
		logic              left_move;
		logic              left_forward;
		logic              right_halt;
		logic [RATE_W-1:0] right_rate;
		logic              right_move;
		logic              right_forward;
	} cvg_rsp_t;

endpackage

### hw/rtl/corexy_velocity_command_gate_top.sv
// Throughput: one request per cycle while rsp is not stalled; the three pipeline registers fill while rsp stalls.
// Stages: input register, gain multiply register, mix and saturate into the result register.
// Reset: clears valid flags, last-rate signs, gains to zero and the deadband to 30.
// ----------------------------------------------------------------------------
// corexy_velocity_command_gate_top
// Gates a cartesian velocity request by the limit switches, mixes it into
// left and right step rates and reports stop, rate, move and direction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module corexy_velocity_command_gate_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  cvg_pkg::cvg_cmd_t             cmd,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output cvg_pkg::cvg_rsp_t             rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cvg_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import cvg_pkg::*;

	logic signed [GAIN_W-1:0] left_gain_x_q;
	logic signed [GAIN_W-1:0] left_gain_y_q;
	logic signed [GAIN_W-1:0] right_gain_x_q;
	logic signed [GAIN_W-1:0] right_gain_y_q;
	logic [DB_W-1:0]          deadband_q;
	cvg_reg_t                 reg_idx;
	logic                     reg_wr;

	logic                     v_s1;
	cvg_cmd_t                 cmd_s1;
	logic                     v_s2;
	logic signed [PROD_W-1:0] prod_lx_s2;
	logic signed [PROD_W-1:0] prod_ly_s2;
	logic signed [PROD_W-1:0] prod_rx_s2;
	logic signed [PROD_W-1:0] prod_ry_s2;
	logic                     rsp_valid_q;
	cvg_rsp_t                 rsp_q;

	logic                     rsp_ready;
	logic                     s2_ready;
	logic                     s1_ready;
	logic                     ld_out;
	logic signed [VEL_W-1:0]  vx_g;
	logic signed [VEL_W-1:0]  vy_g;
	cvg_motor_t               left_res;
	cvg_motor_t               right_res;

	// apb register port
	assign pready  = 1'b1;
	assign reg_idx = cvg_reg_t'(paddr[ADDR_W-1:2]);
	assign reg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_gain_x_q  <= '0;
			left_gain_y_q  <= '0;
			right_gain_x_q <= '0;
			right_gain_y_q <= '0;
			deadband_q     <= DEADBAND_RESET;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_LEFT_GAIN_X:  left_gain_x_q  <= pwdata;
				REG_LEFT_GAIN_Y:  left_gain_y_q  <= pwdata;
				REG_RIGHT_GAIN_X: right_gain_x_q <= pwdata;
				REG_RIGHT_GAIN_Y: right_gain_y_q <= pwdata;
				REG_DEADBAND:     deadband_q     <= pwdata[DB_W-1:0];
				default:          ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_idx)
			REG_LEFT_GAIN_X:  prdata = left_gain_x_q;
			REG_LEFT_GAIN_Y:  prdata = left_gain_y_q;
			REG_RIGHT_GAIN_X: prdata = right_gain_x_q;
			REG_RIGHT_GAIN_Y: prdata = right_gain_y_q;
			REG_DEADBAND:     prdata = {{(32-DB_W){1'b0}}, deadband_q};
			default:          prdata = '0;
		endcase
	end

	// per-stage flow control, each stage loads when empty or draining
	assign rsp_ready = !rsp_valid_q || !rsp_stall;
	assign s2_ready  = !v_s2 || rsp_ready;
	assign s1_ready  = !v_s1 || s2_ready;
	assign cmd_stall = !s1_ready;
	assign ld_out    = v_s2 && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (s1_ready)  v_s1        <= cmd_valid;
			if (s2_ready)  v_s2        <= v_s1;
			if (rsp_ready) rsp_valid_q <= v_s2;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (cmd_valid && s1_ready) begin
			cmd_s1 <= cmd;
		end
	end

	// limit switches block motion further into a pressed switch
	always_comb begin
		vx_g = cmd_s1.vel_x;
		vy_g = cmd_s1.vel_y;
		if ((cmd_s1.limit_switches[SW_LEFT] && cmd_s1.vel_x < 0) ||
			(cmd_s1.limit_switches[SW_RIGHT] && cmd_s1.vel_x > 0)) begin
			vx_g = '0;
		end
		if ((cmd_s1.limit_switches[SW_BOTTOM] && cmd_s1.vel_y < 0) ||
			(cmd_s1.limit_switches[SW_TOP] && cmd_s1.vel_y > 0)) begin
			vy_g = '0;
		end
	end

	// gain products
	always_ff @(posedge clk) begin
		if (v_s1 && s2_ready) begin
			prod_lx_s2 <= PROD_W'(vx_g) * PROD_W'(left_gain_x_q);
			prod_ly_s2 <= PROD_W'(vy_g) * PROD_W'(left_gain_y_q);
			prod_rx_s2 <= PROD_W'(vx_g) * PROD_W'(right_gain_x_q);
			prod_ry_s2 <= PROD_W'(vy_g) * PROD_W'(right_gain_y_q);
		end
	end

	cvg_motor u_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (ld_out),
		.prod_x   (prod_lx_s2),
		.prod_y   (prod_ly_s2),
		.deadband (deadband_q),
		.result   (left_res)
	);

	cvg_motor u_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (ld_out),
		.prod_x   (prod_rx_s2),
		.prod_y   (prod_ry_s2),
		.deadband (deadband_q),
		.result   (right_res)
	);

	// result register
	always_ff @(posedge clk) begin
		if (ld_out) begin
			rsp_q.left_halt     <= left_res.stop;
			rsp_q.left_rate     <= left_res.rate;
			rsp_q.left_move     <= left_res.move;
			rsp_q.left_forward  <= left_res.forward;
			rsp_q.right_halt    <= right_res.stop;
			rsp_q.right_rate    <= right_res.rate;
			rsp_q.right_move    <= right_res.move;
			rsp_q.right_forward <= right_res.forward;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// stall the request side only with every stage occupied
	`ASSERT_ALWAYS(a_stall_full, clk, arst_n, !cmd_stall || (v_s1 && v_s2 && rsp_valid_q))
	// a product stage that cannot drain keeps its contents
	`ASSERT_NEXT(a_s2_hold, clk, arst_n, v_s2 && !rsp_ready,
		v_s2 && $stable(prod_lx_s2) && $stable(prod_ry_s2))
	// a zero left rate always reads as stop, no move, reverse
	`ASSERT_ALWAYS(a_left_zero, clk, arst_n,
		!(rsp_valid_q && !rsp_q.left_move) ||
		(rsp_q.left_halt && !rsp_q.left_forward && rsp_q.left_rate == '0))

endmodule

### hw/rtl/cvg_motor.sv
// ----------------------------------------------------------------------------
// cvg_motor
// One motor's mixing back end: sums the two gain products, truncates toward
// zero, saturates, applies the deadband and derives stop, move and direction
// against the sign of the last delivered rate.
// ----------------------------------------------------------------------------
module cvg_motor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                upd,
	input  logic signed [cvg_pkg::PROD_W-1:0]   prod_x,
	input  logic signed [cvg_pkg::PROD_W-1:0]   prod_y,
	input  logic [cvg_pkg::DB_W-1:0]            deadband,
	output cvg_pkg::cvg_motor_t                 result
);
	import cvg_pkg::*;

	logic signed [SUM_W-1:0] sum;
	logic                    neg;
	logic [SUM_W-1:0]        mag;
	logic [WHOLE_W-1:0]      whole;
	logic [RATE_W-1:0]       lim;
	logic [RATE_W-1:0]       sat;
	logic [RATE_W-1:0]       rate;
	logic                    nonzero;
	logic                    prev_pos_q;
	logic                    prev_neg_q;

	// exact sum, then magnitude with fraction dropped
	always_comb begin
		sum   = SUM_W'(prod_x) + SUM_W'(prod_y);
		neg   = sum[SUM_W-1];
		mag   = neg ? SUM_W'(-sum) : SUM_W'(sum);
		whole = mag[SUM_W-1:FRAC_W];
	end

	// saturate to the signed range, then deadband
	always_comb begin
		lim     = neg ? RATE_MAX_NEG : RATE_MAX_POS;
		sat     = (whole > WHOLE_W'(lim)) ? lim : whole[RATE_W-1:0];
		rate    = (sat < RATE_W'(deadband)) ? '0 : sat;
		nonzero = (rate != '0);
	end

	// result fields
	always_comb begin
		result.rate    = rate;
		result.move    = nonzero;
		result.forward = nonzero && !neg;
		result.stop    = !nonzero || (prev_neg_q && !neg) || (prev_pos_q && neg);
	end

	// sign of the last rate, kept as two flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pos_q <= 1'b0;
			prev_neg_q <= 1'b0;
		end else if (upd) begin
			prev_pos_q <= nonzero && !neg;
			prev_neg_q <= nonzero && neg;
		end
	end

endmodule

### tb/sv/corexy_velocity_command_gate_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// corexy_velocity_command_gate_top_tb
// Self-checking bench for the corexy velocity command gate. A queue-fed
// driver offers velocity requests with random gaps, a monitor stalls the
// result side at random and compares every result against a bit-exact
// predictor of the switch gating, gain mixing, deadband and stop logic.
// Gains and deadband are reloaded over apb between phases while idle.
// ----------------------------------------------------------------------------
module corexy_velocity_command_gate_top_tb;
	import cvg_pkg::*;

	localparam int          IDLE_LIMIT = 5000;
	localparam int          VEL_MAX    = 8388607;
	localparam int          VEL_MIN    = -8388608;
	localparam logic [31:0] GAIN_ONE   = 32'h0001_0000;
	localparam logic [31:0] GAIN_TOP   = 32'h7FFF_FFFF;
	localparam logic [31:0] GAIN_BOT   = 32'h8000_0000;
	localparam logic [3:0]  HIT_LEFT   = 4'(1 << SW_LEFT);
	localparam logic [3:0]  HIT_RIGHT  = 4'(1 << SW_RIGHT);
	localparam logic [3:0]  HIT_BOTTOM = 4'(1 << SW_BOTTOM);
	localparam logic [3:0]  HIT_TOP    = 4'(1 << SW_TOP);

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              cmd_stall;
	cvg_cmd_t          cmd_bus   = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	cvg_rsp_t          rsp_bus;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [31:0]       pwdata    = '0;
	logic [31:0]       prdata;
	logic              pready;

	corexy_velocity_command_gate_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd_bus),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_bus),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// mirrored configuration and last step rates
	logic signed [GAIN_W-1:0] gain_lx = '0;
	logic signed [GAIN_W-1:0] gain_ly = '0;
	logic signed [GAIN_W-1:0] gain_rx = '0;
	logic signed [GAIN_W-1:0] gain_ry = '0;
	logic [DB_W-1:0]          deadband = DEADBAND_RESET;
	logic signed [RATE_W-1:0] last_left_rate  = '0;
	logic signed [RATE_W-1:0] last_right_rate = '0;

	cvg_cmd_t    cmd_queue[$];
	cvg_rsp_t    rate_expect[$];
	cvg_cmd_t    next_cmd;
	cvg_rsp_t    rsp_want;
	int unsigned cmd_queued      = 0;
	int unsigned cmd_accepted    = 0;
	int unsigned results_checked = 0;
	int unsigned fail_count      = 0;
	int unsigned idle_odds       = 0;
	int unsigned cmd_gap         = 0;
	int unsigned rsp_gap         = 0;
	int unsigned rsp_hold        = 0;
	int unsigned next_hold_at    = 100;
	int unsigned idle_cycles     = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// mix one motor: exact sum, truncate toward zero, saturate, deadband
	function automatic logic signed [RATE_W-1:0] mix_rate(input longint vx, input longint vy,
			input longint gx, input longint gy);
		longint sum;
		longint mag;
		logic   neg;
		sum = vx * gx + vy * gy;
		neg = sum < 0;
		mag = neg ? -sum : sum;
		mag = mag >> FRAC_W;
		if (neg && mag > 64'sd8388608)
			mag = 64'sd8388608;
		else if (!neg && mag > 64'sd8388607)
			mag = 64'sd8388607;
		if (mag < longint'(deadband))
			mag = 0;
		return neg ? RATE_W'(-mag) : RATE_W'(mag);
	endfunction

	function automatic cvg_motor_t motor_flags(input logic signed [RATE_W-1:0] prev,
			input logic signed [RATE_W-1:0] now);
		cvg_motor_t m;
		m.stop    = (prev < 0 && now > 0) || (prev > 0 && now < 0) || now == 0;
		m.rate    = now < 0 ? RATE_W'(-now) : now;
		m.move    = now != 0;
		m.forward = now > 0;
		return m;
	endfunction

	// gate by the switches, mix both motors and advance the last rates
	function automatic cvg_rsp_t predict_rates(input cvg_cmd_t c);
		longint                   vx;
		longint                   vy;
		logic signed [RATE_W-1:0] nl;
		logic signed [RATE_W-1:0] nr;
		cvg_motor_t               ml;
		cvg_motor_t               mr;
		cvg_rsp_t                 r;
		vx = longint'(signed'(c.vel_x));
		vy = longint'(signed'(c.vel_y));
		if (c.limit_switches[SW_LEFT] && vx < 0) vx = 0;
		if (c.limit_switches[SW_RIGHT] && vx > 0) vx = 0;
		if (c.limit_switches[SW_BOTTOM] && vy < 0) vy = 0;
		if (c.limit_switches[SW_TOP] && vy > 0) vy = 0;
		nl = mix_rate(vx, vy, longint'(gain_lx), longint'(gain_ly));
		nr = mix_rate(vx, vy, longint'(gain_rx), longint'(gain_ry));
		ml = motor_flags(last_left_rate, nl);
		mr = motor_flags(last_right_rate, nr);
		last_left_rate  = nl;
		last_right_rate = nr;
		r.left_halt     = ml.stop;
		r.left_rate     = ml.rate;
		r.left_move     = ml.move;
		r.left_forward  = ml.forward;
		r.right_halt    = mr.stop;
		r.right_rate    = mr.rate;
		r.right_move    = mr.move;
		r.right_forward = mr.forward;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [RATE_W-1:0] want,
			input logic [RATE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic push_cmd(input int vx, input int vy, input logic [3:0] sw);
		cvg_cmd_t c;
		c.vel_x          = VEL_W'(vx);
		c.vel_y          = VEL_W'(vy);
		c.limit_switches = sw;
		cmd_queue.push_back(c);
		cmd_queued++;
	endtask

	// apb write: setup then access, mirror updated once it lands
	task automatic write_reg(input cvg_reg_t idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_LEFT_GAIN_X:  gain_lx = value;
			REG_LEFT_GAIN_Y:  gain_ly = value;
			REG_RIGHT_GAIN_X: gain_rx = value;
			REG_RIGHT_GAIN_Y: gain_ry = value;
			REG_DEADBAND:     deadband = value[DB_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_config(input logic [31:0] lx, input logic [31:0] ly,
			input logic [31:0] rx, input logic [31:0] ry, input logic [DB_W-1:0] db);
		write_reg(REG_LEFT_GAIN_X, lx);
		write_reg(REG_LEFT_GAIN_Y, ly);
		write_reg(REG_RIGHT_GAIN_X, rx);
		write_reg(REG_RIGHT_GAIN_Y, ry);
		// upper bits are junk, only the low half is the threshold
		write_reg(REG_DEADBAND, {16'($urandom()), db});
	endtask

	// wait until every request is in and every result is back
	task automatic drain_requests();
		while (cmd_accepted != cmd_queued || rate_expect.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic int rand_vel();
		int v;
		int unsigned n;
		case ($urandom_range(0, 5))
			0: v = int'(signed'(VEL_W'($urandom())));
			1: v = 0;
			2: begin
				case ($urandom_range(0, 3))
					0: v = VEL_MAX;
					1: v = VEL_MIN;
					2: v = 1;
					default: v = -1;
				endcase
			end
			default: begin
				n = $urandom_range(1, 23);
				v = int'($urandom() & ((32'd1 << n) - 1));
				if ($urandom_range(0, 1)) v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rand_gain();
		logic [31:0] g;
		int unsigned n;
		case ($urandom_range(0, 4))
			0: g = $urandom();
			1: g = '0;
			default: begin
				n = $urandom_range(8, 26);
				g = $urandom() & ((32'd1 << n) - 1);
				if ($urandom_range(0, 1)) g = -g;
			end
		endcase
		return g;
	endfunction

	// request driver: holds while stalled, otherwise idles or offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd_bus   <= '0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				rate_expect.push_back(predict_rates(cmd_bus));
				cmd_accepted++;
			end
			if (!(cmd_valid && cmd_stall)) begin
				if (cmd_gap == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
					cmd_gap = $urandom_range(1, 7);
				if (cmd_gap != 0) begin
					cmd_gap--;
					cmd_valid <= 1'b0;
				end else if (cmd_queue.size() != 0) begin
					next_cmd = cmd_queue.pop_front();
					cmd_bus   <= next_cmd;
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare against the oldest prediction, then pick the stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (rate_expect.size() == 0) begin
					$error("result with no request pending");
					fail_count++;
				end else begin
					rsp_want = rate_expect.pop_front();
					check_field("left_halt", RATE_W'(rsp_want.left_halt),
						RATE_W'(rsp_bus.left_halt));
					check_field("left_rate", rsp_want.left_rate, rsp_bus.left_rate);
					check_field("left_move", RATE_W'(rsp_want.left_move),
						RATE_W'(rsp_bus.left_move));
					check_field("left_forward", RATE_W'(rsp_want.left_forward),
						RATE_W'(rsp_bus.left_forward));
					check_field("right_halt", RATE_W'(rsp_want.right_halt),
						RATE_W'(rsp_bus.right_halt));
					check_field("right_rate", rsp_want.right_rate, rsp_bus.right_rate);
					check_field("right_move", RATE_W'(rsp_want.right_move),
						RATE_W'(rsp_bus.right_move));
					check_field("right_forward", RATE_W'(rsp_want.right_forward),
						RATE_W'(rsp_bus.right_forward));
				end
				results_checked++;
			end
			// long hold now and then so the pipe backs up into the request side
			if (rsp_hold != 0) begin
				rsp_hold--;
				rsp_stall <= 1'b1;
			end else if (idle_odds != 0 && results_checked >= next_hold_at) begin
				rsp_hold = 79;
				next_hold_at += 600;
				rsp_stall <= 1'b1;
			end else begin
				if (rsp_gap == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
					rsp_gap = $urandom_range(1, 7);
				if (rsp_gap != 0) begin
					rsp_gap--;
					rsp_stall <= 1'b1;
				end else begin
					rsp_stall <= 1'b0;
				end
			end
		end
	end

	// watchdog on cycles with no traffic at all
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		idle_odds = 6;

		// reset values: zero gains, deadband 30
		push_cmd(VEL_MAX, VEL_MIN, 4'h0);
		push_cmd(-1000, 2000, 4'h0);
		drain_requests();

		// corexy mixing at gain 1/256: left = (x + y) / 256, right = (x - y) / 256
		load_config(GAIN_ONE, GAIN_ONE, GAIN_ONE, -GAIN_ONE, DEADBAND_RESET);
		push_cmd(7680, 0, 4'h0);
		push_cmd(7679, 0, 4'h0);
		push_cmd(-7680, 0, 4'h0);
		push_cmd(7680, 0, 4'h0);
		push_cmd(VEL_MAX, VEL_MAX, 4'h0);
		push_cmd(VEL_MIN, VEL_MIN, 4'h0);
		push_cmd(VEL_MAX, VEL_MIN, 4'h0);
		push_cmd(-100000, 0, HIT_LEFT);
		push_cmd(100000, 0, HIT_LEFT);
		push_cmd(100000, 0, HIT_RIGHT);
		push_cmd(-100000, 0, HIT_RIGHT);
		push_cmd(0, -100000, HIT_BOTTOM);
		push_cmd(0, 100000, HIT_BOTTOM);
		push_cmd(0, 100000, HIT_TOP);
		push_cmd(0, -100000, HIT_TOP);
		push_cmd(100000, -100000, 4'hF);
		push_cmd(-100000, 100000, 4'hF);
		push_cmd(-256, 0, 4'h0);
		push_cmd(0, 0, 4'h0);
		drain_requests();

		// extreme gains, no deadband: both saturation limits
		load_config(GAIN_TOP, GAIN_TOP, GAIN_BOT, GAIN_BOT, '0);
		push_cmd(VEL_MAX, VEL_MAX, 4'h0);
		push_cmd(VEL_MIN, VEL_MIN, 4'h0);
		push_cmd(1, 0, 4'h0);
		push_cmd(-1, -1, 4'h0);
		push_cmd(0, 0, 4'h0);
		drain_requests();

		// random phases, each with its own gains and deadband
		for (int p = 0; p < 8; p++) begin
			idle_odds = (p == 3 || p == 7) ? 0 : ((p % 2 != 0) ? 4 : 9);
			case (p % 4)
				0: load_config(rand_gain(), rand_gain(), rand_gain(), rand_gain(), 16'hFFFF);
				1: load_config(rand_gain(), rand_gain(), rand_gain(), rand_gain(), '0);
				2: load_config(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
						DEADBAND_RESET);
				default: load_config(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
						DB_W'($urandom_range(0, 4096)));
			endcase
			for (int i = 0; i < 210; i++)
				push_cmd(rand_vel(), rand_vel(),
						($urandom_range(0, 3) == 0) ? 4'h0 : 4'($urandom()));
			drain_requests();
		end

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
